### rtl/core/kfti_pkg.sv
`timescale 1ns / 1ps
package kfti_pkg;
    localparam int unsigned DEFAULT_RATE = 7680;
    localparam logic [31:0] UNIT_Q16 = 32'h0001_0000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] REG_TICK_RATE = 2'd0;
    localparam logic [1:0] REG_DURATION  = 2'd1;
    localparam logic [1:0] REG_KEY_COUNT = 2'd2;
    localparam logic [1:0] REG_TRACK_KIND = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture query and start the time scaling
        logic scale;     // finish scaled time and clamp
        logic rd;        // issue memory read at the search index
        logic cmp;       // compare read time against t
        logic div_start; // latch pair and start the divider
        logic div_step;  // one divider iteration
        logic blend;     // multiply
        logic finish;    // add and load the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic empty;     // no keys
        logic last;      // search index reached the last key
        logic stop;      // key time above t found
        logic div_done;
    } t_sts;
endpackage

### rtl/core/kfti_ctrl.sv
`timescale 1ns / 1ps
module kfti_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  kfti_pkg::t_sts    i_sts,
    output kfti_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCALE = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_WAIT  = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_PAIR  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.empty || i_sts.last) n_state = S_PAIR;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_CMP;
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_sts.stop ? S_PAIR : S_RD;
            end
            S_PAIR: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_MUL;
                else o_cmd.div_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.blend = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.rd, o_cmd.div_start, o_cmd.finish}))
        else $error("conflicting commands");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("finish did not return to idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("query loaded while busy");
endmodule

### rtl/core/kfti_dp.sv
`timescale 1ns / 1ps
module kfti_dp #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic [5:0]                    i_slot,
    input  logic [31:0]                   i_key_time,
    input  logic [31:0]                   i_key_x,
    input  logic [31:0]                   i_key_y,
    input  logic [31:0]                   i_key_z,
    input  logic [31:0]                   i_query_time,
    input  logic [15:0]                   i_tick_rate,
    input  logic [31:0]                   i_duration,
    input  logic [6:0]                    i_key_count,
    input  logic                          i_track_kind,
    input  kfti_pkg::t_cmd                i_cmd,
    output kfti_pkg::t_sts                o_sts,
    output logic [31:0]                   o_x,
    output logic [31:0]                   o_y,
    output logic [31:0]                   o_z,
    output logic                          o_finished,
    output logic [15:0]                   o_frame
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = AW + 1;
    localparam int NW = 32 + FRAC_BITS;
    localparam int DIVW = $clog2(NW + 1);
    localparam logic [NW:0] ONE = (NW + 1)'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        M_DIVIDE = 2'd0,
        M_ZERO   = 2'd1,
        M_ONE    = 2'd2
    } t_mode;

    logic [127:0] r_mem [MAX_KEYS];
    logic [127:0] r_rd;
    logic [127:0] r_k0, r_k1;
    logic [47:0]  r_prod;
    logic [31:0]  r_t;
    logic         r_fin;
    logic [CW-1:0] r_n, r_ri;
    logic         r_stop;
    logic [NW-1:0] r_num;
    logic [32:0]  r_rem;
    logic [31:0]  r_den;
    logic [DIVW-1:0] r_cnt;
    t_mode        r_mode;
    logic [2:0][63:0] r_mul;

    // Writes accepted only when slot lies inside the store.
    always_ff @(posedge i_clk) begin
        if (i_wr && (32'(i_slot) < 32'(MAX_KEYS)))
            r_mem[AW'(i_slot)] <= {i_key_z, i_key_y, i_key_x, i_key_time};
        if (i_cmd.rd) r_rd <= r_mem[r_ri[AW-1:0]];
    end

    wire [CW-1:0] w_n = (32'(i_key_count) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                            : CW'(i_key_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= i_query_time * i_tick_rate;
            r_n <= w_n;
            r_ri <= '0;
            r_stop <= 1'b0;
        end
        if (i_cmd.scale) begin
            logic [31:0] s;
            s = (|r_prod[47:40]) ? 32'hFFFF_FFFF : r_prod[39:8];
            r_t <= (s < i_duration) ? s : i_duration;
            r_fin <= (s >= i_duration);
        end
        // Entry r_ri holds key i+1 once i advances; key i is kept in r_k0.
        if (i_cmd.cmp) begin
            if (r_ri == '0) begin
                r_k0 <= r_rd;
                r_ri <= r_ri + 1'b1;
                r_stop <= 1'b0;
            end else if (r_t < r_rd[31:0]) begin
                r_k1 <= r_rd;
                r_stop <= 1'b1;
            end else begin
                r_k0 <= r_rd;
                r_ri <= r_ri + 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_num <= NW'(r_t - r_k0[31:0]) << FRAC_BITS;
            r_rem <= '0;
            r_den <= r_k1[31:0] - r_k0[31:0];
            r_cnt <= DIVW'(NW);
            if (!r_stop) r_mode <= M_ZERO;
            else if (r_k1[31:0] <= r_k0[31:0]) r_mode <= M_ONE;
            else if (r_t <= r_k0[31:0]) r_mode <= M_ZERO;
            else r_mode <= M_DIVIDE;
        end
        if (i_cmd.div_step) begin
            logic [32:0] rr;
            rr = {r_rem[31:0], r_num[NW-1]};
            if (rr >= {1'b0, r_den}) begin
                r_rem <= rr - {1'b0, r_den};
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= rr;
                r_num <= {r_num[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.blend) begin
            logic [NW:0] f;
            if (r_mode == M_ZERO) f = '0;
            else if (r_mode == M_ONE) f = ONE;
            else f = ({1'b0, r_num} > ONE) ? ONE : {1'b0, r_num};
            for (int c = 0; c < 3; c++) begin
                logic signed [32:0] d;
                d = $signed({r_k1[32*c+63], r_k1[32*c+32 +: 32]})
                  - $signed({r_k0[32*c+63], r_k0[32*c+32 +: 32]});
                r_mul[c] <= 64'($signed(d) * $signed({1'b0, f[FRAC_BITS:0]}));
            end
        end
        if (i_cmd.finish) begin
            logic [2:0][31:0] v;
            for (int c = 0; c < 3; c++) begin
                if (r_n == '0) v[c] = i_track_kind ? kfti_pkg::UNIT_Q16 : 32'd0;
                else if (!r_stop) v[c] = r_k0[32*c+32 +: 32];
                else v[c] = r_k0[32*c+32 +: 32]
                          + 32'($signed(r_mul[c]) >>> FRAC_BITS);
            end
            o_x <= v[0];
            o_y <= v[1];
            o_z <= v[2];
            o_finished <= r_fin;
            o_frame <= r_t[31:16];
        end
    end

    // Search index r_ri; the last key is reached when r_ri passes r_n-1.
    always_comb begin
        o_sts.empty = (r_n == '0);
        o_sts.last = (r_ri != '0) && (r_ri >= r_n);
        o_sts.stop = (r_ri != '0) && (r_t < r_rd[31:0]);
        o_sts.div_done = (r_mode != M_DIVIDE) || (r_cnt == '0);
    end
endmodule

### rtl/core/keyframe_track_interpolator.sv
`timescale 1ns / 1ps
// Linear keyframe track: write transactions store time-sorted vec3 keys, query
// transactions return one interpolated value with a finished flag and frame.
// One item at a time; a query holds off the input while it runs: a linear key
// search reads the key memory one key at a time, each read waiting on the
// memory before its compare, then a restoring divider forms the fraction one
// quotient bit per cycle over 32 + FRAC_BITS bits, skipped when the fraction
// is 0 or 1. A result still waiting on the output stalls the next query at
// its last step.
module keyframe_track_interpolator #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], query_time[165:134], zero fill
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], finished[96], frame[112:97]
    output logic [119:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    logic [15:0] r_tick_rate;
    logic [31:0] r_duration;
    logic [6:0]  r_key_count;
    logic        r_track_kind;
    logic        r_ovalid;
    logic        w_busy;
    kfti_pkg::t_cmd w_cmd;
    kfti_pkg::t_sts w_sts;
    logic [31:0] w_x, w_y, w_z;
    logic        w_fin;
    logic [15:0] w_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= 16'(kfti_pkg::DEFAULT_RATE);
            r_duration <= '0;
            r_key_count <= '0;
            r_track_kind <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kfti_pkg::REG_TICK_RATE:  r_tick_rate <= i_cfg_data[15:0];
                kfti_pkg::REG_DURATION:   r_duration <= i_cfg_data;
                kfti_pkg::REG_KEY_COUNT:  r_key_count <= i_cfg_data[6:0];
                kfti_pkg::REG_TRACK_KIND: r_track_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    wire w_acc = s_axis_tvalid && s_axis_tready;
    wire w_wr = w_acc && (s_axis_tuser == kfti_pkg::KIND_WRITE);
    wire w_q = w_acc && (s_axis_tuser == kfti_pkg::KIND_QUERY);
    wire w_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    kfti_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_q), .i_out_free(w_free),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    kfti_dp #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_wr(w_wr), .i_slot(s_axis_tdata[5:0]),
        .i_key_time(s_axis_tdata[37:6]), .i_key_x(s_axis_tdata[69:38]),
        .i_key_y(s_axis_tdata[101:70]), .i_key_z(s_axis_tdata[133:102]),
        .i_query_time(s_axis_tdata[165:134]), .i_tick_rate(r_tick_rate),
        .i_duration(r_duration), .i_key_count(r_key_count),
        .i_track_kind(r_track_kind), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_x(w_x), .o_y(w_y), .o_z(w_z), .o_finished(w_fin), .o_frame(w_frame)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, w_frame, w_fin, w_z, w_y, w_x};

    logic unused;
    assign unused = ^s_axis_tdata[167:166];
endmodule
